[sv/serial_frame_dedup_receiver_unit_assert.svh]
// Assertion macros used by the checker file of the frame receiver.
// Depends on nothing; included by bare file name.
`ifndef SERIAL_FRAME_DEDUP_RECEIVER_UNIT_ASSERT_SVH
`define SERIAL_FRAME_DEDUP_RECEIVER_UNIT_ASSERT_SVH

// Concurrent assertion on a given clock and active-low reset.
`define SFDR_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the usual clk_i / rst_ni pair.
`define SFDR_ASSERT(lbl, prop, msg) \
  `SFDR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[sv/sfdr_pkg.sv]
// Types and constants of the serial frame receiver.
// Depends on nothing; used by sfdr_check, the top level and the checker.
`default_nettype none
package sfdr_pkg;

  localparam int unsigned WinLen = 15;

  localparam logic [7:0] SyncByte  = 8'hA5;
  localparam logic [7:0] TypeRobot = 8'h10;
  localparam logic [7:0] TypeKey   = 8'h30;
  localparam logic [7:0] CmdLow    = 8'h80;
  localparam logic [7:0] CmdHigh   = 8'h83;
  // bit 1 of payload byte 5 sits at bit 17 of the payload head
  localparam int unsigned HoldBitPos = 17;

  typedef logic [WinLen-1:0][7:0] win_t;  // index 0 is the oldest byte

  typedef enum logic {
    KindRobot = 1'b0,
    KindKey   = 1'b1
  } frame_kind_e;

  typedef struct packed {
    logic        is_frame;   // sync, known type, robot command in range
    frame_kind_e kind;
    logic        good;       // checksum matches
    logic [63:0] head;       // payload bytes 0..7
    logic [31:0] tail;       // payload bytes 8..11 as they stand in the window
    logic        hold;       // bit 1 of payload byte 5
  } chk_t;

endpackage
`default_nettype wire

[sv/sfdr_if.sv]
// Valid/ready channel interfaces of the frame receiver: received bytes in,
// frames out. Depends on nothing.
`default_nettype none
interface sfdr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       host_busy;

  modport source (output valid, output rx_byte, output host_busy, input ready);
  modport sink (input valid, input rx_byte, input host_busy, output ready);
endinterface

interface sfdr_frame_if;
  logic        valid;
  logic        ready;
  logic        frame_kind;
  logic [63:0] payload_head;
  logic [31:0] payload_tail;
  logic        is_resend;

  modport source (output valid, output frame_kind, output payload_head,
                  output payload_tail, output is_resend, input ready);
  modport sink (input valid, input frame_kind, input payload_head,
                input payload_tail, input is_resend, output ready);
endinterface
`default_nettype wire

[sv/sfdr_check.sv]
// Frame decoder: sync, type, command range and checksum of the 15-byte window.
// Depends on sfdr_pkg.
`default_nettype none
module sfdr_check (
  input  sfdr_pkg::win_t win_i,
  output sfdr_pkg::chk_t chk_o
);

  logic [6:0][7:0] pair_sum;
  logic [7:0]      sum;
  logic            is_robot;
  logic            is_key;
  logic            cmd_ok;

  always_comb begin
    for (int i = 0; i < 7; i++) begin
      pair_sum[i] = win_i[2*i] + win_i[2*i+1];
    end
    sum = 8'h00;
    for (int i = 0; i < 7; i++) begin
      sum = sum + pair_sum[i];
    end
  end

  assign is_robot = (win_i[1] == sfdr_pkg::TypeRobot);
  assign is_key   = (win_i[1] == sfdr_pkg::TypeKey);
  assign cmd_ok   = (win_i[2] >= sfdr_pkg::CmdLow) && (win_i[2] <= sfdr_pkg::CmdHigh);

  always_comb begin
    chk_o.is_frame = (win_i[0] == sfdr_pkg::SyncByte) && ((is_robot && cmd_ok) || is_key);
    chk_o.kind     = is_key ? sfdr_pkg::KindKey : sfdr_pkg::KindRobot;
    chk_o.good     = (sum == win_i[14]);
    chk_o.head     = {win_i[2], win_i[3], win_i[4], win_i[5],
                      win_i[6], win_i[7], win_i[8], win_i[9]};
    chk_o.tail     = {win_i[10], win_i[11], win_i[12], win_i[13]};
    chk_o.hold     = win_i[7][1];
  end

endmodule
`default_nettype wire

[sv/serial_frame_dedup_receiver_unit.sv]
// Serial frame receiver with duplicate suppression: top level.
// Depends on sfdr_pkg, sfdr_if and sfdr_check.
//
//  channel | modport | transfer payload
//  rx_i    | sink    | rx_byte, host_busy
//  frame_o | source  | frame_kind, payload_head, payload_tail, is_resend
//
// One byte per cycle while rx_i is ready. A transfer shifts the byte into the
// window register; once the result register is free, the window is decoded,
// the stored copies are updated and the result register is loaded.
// rx_i stalls only while a byte waits and the result register is held by frame_o.
// Reset clears the window, the valid and delivered flags; copies are unset.
`default_nettype none
module serial_frame_dedup_receiver_unit (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  sfdr_rx_if.sink       rx_i,
  sfdr_frame_if.source  frame_o
);

  sfdr_pkg::win_t win_q, win_d;
  logic           pend_q;
  logic           busy_q;
  logic           advance;
  logic           rx_xfer;

  sfdr_pkg::chk_t chk;

  logic [3:0][63:0] rob_head_q;
  logic [3:0][23:0] rob_tail_q;
  logic [3:0]       rob_valid_q, rob_valid_d;
  logic [1:0]       rob_last_q, rob_last_d;
  logic             rob_deliv_q, rob_deliv_d;
  logic [63:0]      key_head_q;
  logic [31:0]      key_tail_q;
  logic             key_valid_q, key_valid_d;
  logic             key_deliv_q, key_deliv_d;

  logic [1:0]  rd_slot;
  logic [63:0] rc_head;
  logic [23:0] rc_tail;
  logic        rob_wr;
  logic        key_wr;
  logic        emit;
  logic        res_resend;
  sfdr_pkg::frame_kind_e res_kind;
  logic [63:0] res_head;
  logic [31:0] res_tail;

  logic        out_valid_q, out_valid_d;
  logic        out_kind_q;
  logic [63:0] out_head_q;
  logic [31:0] out_tail_q;
  logic        out_resend_q;

  assign advance    = pend_q && (!out_valid_q || frame_o.ready);
  assign rx_i.ready = !pend_q || advance;
  assign rx_xfer    = rx_i.valid && rx_i.ready;

  always_comb begin
    for (int i = 0; i < sfdr_pkg::WinLen - 1; i++) begin
      win_d[i] = win_q[i+1];
    end
    win_d[sfdr_pkg::WinLen-1] = rx_i.rx_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pend_q <= 1'b0;
      busy_q <= 1'b0;
    end else begin
      if (rx_xfer) begin
        win_q  <= win_d;
        busy_q <= rx_i.host_busy;
      end
      pend_q <= rx_xfer || (pend_q && !advance);
    end
  end

  sfdr_check u_check (
    .win_i (win_q),
    .chk_o (chk)
  );

  assign rd_slot = chk.good ? chk.head[57:56] : rob_last_q;
  assign rc_head = rob_head_q[rd_slot];
  assign rc_tail = rob_tail_q[rd_slot];

  always_comb begin
    rob_valid_d = rob_valid_q;
    rob_last_d  = rob_last_q;
    rob_deliv_d = rob_deliv_q;
    key_valid_d = key_valid_q;
    key_deliv_d = key_deliv_q;
    rob_wr      = 1'b0;
    key_wr      = 1'b0;
    emit        = 1'b0;
    res_resend  = 1'b0;
    res_kind    = chk.kind;
    res_head    = chk.head;
    res_tail    = chk.tail;
    if (advance && chk.is_frame) begin
      if (chk.kind == sfdr_pkg::KindRobot) begin
        if (chk.good) begin
          rob_last_d = rd_slot;
          res_tail   = {chk.tail[31:8], 8'h00};
          if (!(rob_valid_q[rd_slot] && rc_head == chk.head
                && rc_tail == chk.tail[31:8])) begin
            rob_wr               = 1'b1;
            rob_valid_d[rd_slot] = 1'b1;
            rob_deliv_d          = !busy_q;
            emit                 = !busy_q;
          end
        end else if (!rob_deliv_q && rob_valid_q[rd_slot] && !busy_q) begin
          rob_deliv_d = 1'b1;
          emit        = 1'b1;
          res_resend  = 1'b1;
          res_head    = rc_head;
          res_tail    = {rc_tail, 8'h00};
        end
      end else begin
        if (chk.good) begin
          if (!(key_valid_q && key_head_q == chk.head && key_tail_q == chk.tail)) begin
            key_wr      = 1'b1;
            key_valid_d = 1'b1;
            key_deliv_d = !busy_q;
            emit        = !busy_q && (!key_valid_q || !chk.hold
                                      || !key_head_q[sfdr_pkg::HoldBitPos]);
          end
        end else if (!key_deliv_q && key_valid_q && !busy_q) begin
          key_deliv_d = 1'b1;
          emit        = !(chk.hold && key_head_q[sfdr_pkg::HoldBitPos]);
          res_resend  = 1'b1;
          res_head    = key_head_q;
          res_tail    = key_tail_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rob_valid_q <= '0;
      rob_last_q  <= '0;
      rob_deliv_q <= 1'b0;
      key_valid_q <= 1'b0;
      key_deliv_q <= 1'b0;
    end else begin
      rob_valid_q <= rob_valid_d;
      rob_last_q  <= rob_last_d;
      rob_deliv_q <= rob_deliv_d;
      key_valid_q <= key_valid_d;
      key_deliv_q <= key_deliv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rob_wr) begin
      rob_head_q[rd_slot] <= chk.head;
      rob_tail_q[rd_slot] <= chk.tail[31:8];
    end
    if (key_wr) begin
      key_head_q <= chk.head;
      key_tail_q <= chk.tail;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = emit;
    end else if (frame_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_kind_q   <= res_kind;
      out_head_q   <= res_head;
      out_tail_q   <= res_tail;
      out_resend_q <= res_resend;
    end
  end

  assign frame_o.valid        = out_valid_q;
  assign frame_o.frame_kind   = out_kind_q;
  assign frame_o.payload_head = out_head_q;
  assign frame_o.payload_tail = out_tail_q;
  assign frame_o.is_resend    = out_resend_q;

endmodule
`default_nettype wire

[sv/sfdr_checker.sv]
// Port-level checks of the frame receiver, bound to the top level.
// Depends on sfdr_pkg and serial_frame_dedup_receiver_unit_assert.svh.
`default_nettype none
`include "serial_frame_dedup_receiver_unit_assert.svh"
module sfdr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        out_kind_i,
  input wire logic [63:0] out_head_i,
  input wire logic [31:0] out_tail_i,
  input wire logic        out_resend_i
);

  logic stalled;
  logic robot_out;

  assign stalled   = out_valid_i && !out_ready_i;
  assign robot_out = out_valid_i && (out_kind_i == sfdr_pkg::KindRobot);

  `SFDR_ASSERT(a_hold_stalled, stalled |=> out_valid_i && $stable(out_head_i) && $stable(out_tail_i) && $stable(out_kind_i) && $stable(out_resend_i), "frame changed while stalled")
  `SFDR_ASSERT(a_robot_spare, robot_out |-> out_tail_i[7:0] == 8'h00, "robot frame spare byte not zero")
  `SFDR_ASSERT(a_ready_before_frame, $rose(out_valid_i) |-> $past(in_ready_i), "frame loaded while input stalled")
  `SFDR_ASSERT(a_ready_when_empty, !out_valid_i |-> in_ready_i, "input stalled with empty output")

endmodule

bind serial_frame_dedup_receiver_unit sfdr_checker u_sfdr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (rx_i.ready),
  .out_valid_i  (frame_o.valid),
  .out_ready_i  (frame_o.ready),
  .out_kind_i   (frame_o.frame_kind),
  .out_head_i   (frame_o.payload_head),
  .out_tail_i   (frame_o.payload_tail),
  .out_resend_i (frame_o.is_resend)
);
`default_nettype wire
